### sv/vhcld_pkg.sv
// shared types and constants of the voltage heat colour led driver
// used by the controller, the datapath, the divider and the top level
package vhcld_pkg;

    // field widths
    localparam int ADC_W  = 12;
    localparam int DUTY_W = 16;
    localparam int SM_W   = 24;
    localparam int U_W    = 18;
    localparam int CNT_W  = 12;
    localparam int DEN_W  = 12;
    localparam int MUL_AW = 24;
    localparam int MUL_W  = MUL_AW + DUTY_W;
    localparam int FRAC_W = 8;
    localparam int RADIX  = 2;

    // register indexes of the configuration port
    localparam int CFG_AW = 2;
    typedef enum logic [CFG_AW-1:0] {
        CFG_FULL_SCALE = 2'd0,
        CFG_SPAN_LOW   = 2'd1,
        CFG_SPAN_HIGH  = 2'd2,
        CFG_LOW_SUPPLY = 2'd3
    } t_cfg_idx;

    // reset values of the configuration registers
    localparam logic [DUTY_W-1:0] RST_PERIOD    = 16'd1000;
    localparam logic [ADC_W-1:0]  RST_SPAN_LOW  = 12'd819;
    localparam logic [ADC_W-1:0]  RST_SPAN_HIGH = 12'd2047;
    localparam logic [ADC_W-1:0]  RST_LOW_SUP   = 12'd0;

    // flash windows, open at both ends
    localparam logic [CNT_W-1:0] FL_W1_LO = 12'd100;
    localparam logic [CNT_W-1:0] FL_W1_HI = 12'd200;
    localparam logic [CNT_W-1:0] FL_W2_LO = 12'd400;
    localparam logic [CNT_W-1:0] FL_W2_HI = 12'd500;
    localparam logic [CNT_W-1:0] FL_W3_LO = 12'd700;
    localparam logic [CNT_W-1:0] FL_W3_HI = 12'd800;

    // colour channel
    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2
    } t_ch;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic mul_u;
        logic div_u_go;
        logic take_u;
        logic seg;
        logic mul_f;
        logic div_f_go;
        logic wr_f;
        logic load_out;
        t_ch  ch;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic sat;
        logic div_done;
    } t_sts;

endpackage

### sv/voltage_heat_color_led_driver.sv
// top level of the voltage heat colour led driver
// joins vhcld_ctrl and vhcld_dp; types and constants from vhcld_pkg
//
// One item per millisecond carries a supply and a level reading. The level is
// scaled over [span_low, span_high] to a position, mapped through four colour
// segments to RGB targets, smoothed by a first-order q.8 filter and clamped to
// the full-scale period; below low_supply_threshold a white flash overrides the
// duties in three windows of each FLASH_CYCLE_MS items. One item is in work at a
// time. The numerator width NUM_W of the single shared divider is 32 for the
// default SMOOTH_DIVISOR; the divider delivers two quotient bits per cycle and
// runs once for the span and once per colour filter, and no span division is
// made when the level lies on or outside the ends of the span. The next item is
// taken while a finished result still waits on the output side.
module voltage_heat_color_led_driver
    import vhcld_pkg::*;
#(
    parameter int SMOOTH_DIVISOR = 100,
    parameter int FLASH_CYCLE_MS = 2500
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration write port
    input  logic                i_cfg_we,
    input  logic [CFG_AW-1:0]   i_cfg_addr,
    input  logic [DUTY_W-1:0]   i_cfg_wdata,
    // input items
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [2*ADC_W-1:0]  i_s_tdata,   // supply_reading, level_reading
    // result items
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [3*DUTY_W-1:0] o_m_tdata,   // red_duty, green_duty, blue_duty
    output logic                o_m_tuser    // flash_active
);

    t_cmd cmd;
    t_sts sts;

    vhcld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    vhcld_dp #(
        .SMOOTH_DIVISOR (SMOOTH_DIVISOR),
        .FLASH_CYCLE_MS (FLASH_CYCLE_MS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

### sv/vhcld_div.sv
// shared restoring divider, two quotient bits per cycle
// depends on vhcld_pkg for the divisor width and radix
module vhcld_div
    import vhcld_pkg::*;
#(
    parameter int NUM_W = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int STEPS = NUM_W / RADIX;
    localparam int CW    = $clog2(STEPS + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [NUM_W-1:0] r_q, n_q;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   trial;

    // two restoring steps per cycle
    always_comb begin
        n_rem = r_rem;
        n_q   = r_q;
        trial = '0;
        for (int k = 0; k < RADIX; k++) begin
            trial = {n_rem, n_q[NUM_W-1]};
            n_q   = {n_q[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, r_den}) begin
                trial  = trial - {1'b0, r_den};
                n_q[0] = 1'b1;
            end
            n_rem = trial[DEN_W-1:0];
        end
    end

    // step counter and done pulse
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(STEPS);
        end else if (r_busy) begin
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // operand and partial result registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

### sv/vhcld_dp.sv
// datapath: configuration registers, span scaling, colour segments,
// smoothing filters, flash timer and result register; uses vhcld_pkg, vhcld_div
module vhcld_dp
    import vhcld_pkg::*;
#(
    parameter int SMOOTH_DIVISOR = 100,
    parameter int FLASH_CYCLE_MS = 2500
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_AW-1:0]   i_cfg_addr,
    input  logic [DUTY_W-1:0]   i_cfg_wdata,
    input  logic [2*ADC_W-1:0]  i_s_tdata,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    output logic [3*DUTY_W-1:0] o_m_tdata,
    output logic                o_m_tuser
);

    // numerator wide enough for both the span and the filter divisions
    localparam int SUM_W = SM_W + $clog2(SMOOTH_DIVISOR);
    localparam int RAW_W = (SUM_W > 30) ? SUM_W : 30;
    localparam int NUM_W = RAW_W + (RAW_W % 2);

    logic [DUTY_W-1:0] r_period;
    logic [ADC_W-1:0]  r_span_low, r_span_high, r_low_sup;
    logic [ADC_W-1:0]  r_level;
    logic              r_flash;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [U_W-1:0]    r_u;
    logic [MUL_W-1:0]  r_prod;
    logic [DUTY_W-1:0] r_tgt [3];
    logic [DUTY_W-1:0] n_tgt [3];
    logic [SM_W-1:0]   r_smooth [3];
    logic [DUTY_W-1:0] duty [3];

    logic [ADC_W-1:0]  supply, level, diff, span_d;
    logic              win, flash;
    logic [MUL_AW-1:0] mul_a;
    logic [DUTY_W-1:0] mul_b;
    logic [U_W-1:0]    p1, p2, p3, p4;
    logic              div_start, div_done;
    logic [NUM_W-1:0]  div_num, div_quot;
    logic [DEN_W-1:0]  div_den;

    assign supply = i_s_tdata[ADC_W-1:0];
    assign level  = i_s_tdata[2*ADC_W-1:ADC_W];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= RST_PERIOD;
            r_span_low  <= RST_SPAN_LOW;
            r_span_high <= RST_SPAN_HIGH;
            r_low_sup   <= RST_LOW_SUP;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_FULL_SCALE: r_period    <= i_cfg_wdata;
                CFG_SPAN_LOW:   r_span_low  <= i_cfg_wdata[ADC_W-1:0];
                CFG_SPAN_HIGH:  r_span_high <= i_cfg_wdata[ADC_W-1:0];
                CFG_LOW_SUPPLY: r_low_sup   <= i_cfg_wdata[ADC_W-1:0];
                default: ;
            endcase
        end
    end

    // flash window check on the count before it advances
    always_comb begin
        win = ((r_cnt > FL_W1_LO) && (r_cnt < FL_W1_HI)) ||
              ((r_cnt > FL_W2_LO) && (r_cnt < FL_W2_HI)) ||
              ((r_cnt > FL_W3_LO) && (r_cnt < FL_W3_HI));
        flash = (supply < r_low_sup) && win;
        n_cnt = r_cnt + CNT_W'(1);
        if (n_cnt >= CNT_W'(FLASH_CYCLE_MS)) begin
            n_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load_in) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_level <= level;
            r_flash <= flash;
        end
    end

    // saturation at both ends of the span
    assign diff      = r_level - r_span_low;
    assign span_d    = r_span_high - r_span_low;
    assign o_sts.sat = (r_level <= r_span_low) || (r_level >= r_span_high);

    // shared multiplier, span product or filter feedback product
    always_comb begin
        mul_a = MUL_AW'(diff);
        mul_b = r_period;
        if (i_cmd.mul_f) begin
            mul_a = r_smooth[i_cmd.ch];
            mul_b = DUTY_W'(SMOOTH_DIVISOR - 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_u || i_cmd.mul_f) begin
            r_prod <= MUL_W'(mul_a) * MUL_W'(mul_b);
        end
    end

    // divider operands
    always_comb begin
        div_start = i_cmd.div_u_go || i_cmd.div_f_go;
        if (i_cmd.div_f_go) begin
            div_num = NUM_W'({r_tgt[i_cmd.ch], {FRAC_W{1'b0}}}) + NUM_W'(r_prod);
            div_den = DEN_W'(SMOOTH_DIVISOR);
        end else begin
            div_num = NUM_W'({r_prod, 2'b00});
            div_den = span_d;
        end
    end

    vhcld_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_sts.div_done = div_done;

    // scaled position, 0 to four periods
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_u && o_sts.sat) begin
            r_u <= (r_level <= r_span_low) ? '0 : p4;
        end else if (i_cmd.take_u) begin
            r_u <= div_quot[U_W-1:0];
        end
    end

    // four linear colour segments
    always_comb begin
        p1 = U_W'(r_period);
        p2 = p1 << 1;
        p3 = p2 + p1;
        p4 = p1 << 2;
        if (r_u < p1) begin
            n_tgt[CH_RED]   = '0;
            n_tgt[CH_GREEN] = r_u[DUTY_W-1:0];
            n_tgt[CH_BLUE]  = r_period;
        end else if (r_u < p2) begin
            n_tgt[CH_RED]   = '0;
            n_tgt[CH_GREEN] = r_period;
            n_tgt[CH_BLUE]  = DUTY_W'(p2 - r_u);
        end else if (r_u < p3) begin
            n_tgt[CH_RED]   = DUTY_W'(r_u - p2);
            n_tgt[CH_GREEN] = r_period;
            n_tgt[CH_BLUE]  = '0;
        end else begin
            n_tgt[CH_RED]   = r_period;
            n_tgt[CH_GREEN] = DUTY_W'(p4 - r_u);
            n_tgt[CH_BLUE]  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.seg) begin
            r_tgt <= n_tgt;
        end
    end

    // smoothed duties in q.8
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth[CH_RED]   <= '0;
            r_smooth[CH_GREEN] <= '0;
            r_smooth[CH_BLUE]  <= '0;
        end else if (i_cmd.wr_f) begin
            r_smooth[i_cmd.ch] <= div_quot[SM_W-1:0];
        end
    end

    // clamp to the period, white flash overrides
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            duty[c] = r_smooth[c][SM_W-1:FRAC_W];
            if (duty[c] > r_period || r_flash) begin
                duty[c] = r_period;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_m_tdata <= {duty[CH_BLUE], duty[CH_GREEN], duty[CH_RED]};
            o_m_tuser <= r_flash;
        end
    end

endmodule

### sv/vhcld_ctrl.sv
// controller: sequences one item through scaling, segments and the
// three filter divisions, and owns the result handshake; uses vhcld_pkg
module vhcld_ctrl
    import vhcld_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_U,
        S_DIVU_GO,
        S_DIVU_WAIT,
        S_SEG,
        S_MUL_F,
        S_DIVF_GO,
        S_DIVF_WAIT,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    t_ch    r_ch, n_ch;
    logic   r_m_valid, n_m_valid;
    logic   out_free;

    assign out_free   = !r_m_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;

    // command decode
    always_comb begin
        o_cmd          = '0;
        o_cmd.ch       = r_ch;
        o_cmd.load_in  = (r_state == S_IDLE) && i_s_tvalid;
        o_cmd.mul_u    = (r_state == S_MUL_U);
        o_cmd.div_u_go = (r_state == S_DIVU_GO);
        o_cmd.take_u   = (r_state == S_DIVU_WAIT) && i_sts.div_done;
        o_cmd.seg      = (r_state == S_SEG);
        o_cmd.mul_f    = (r_state == S_MUL_F);
        o_cmd.div_f_go = (r_state == S_DIVF_GO);
        o_cmd.wr_f     = (r_state == S_DIVF_WAIT) && i_sts.div_done;
        o_cmd.load_out = (r_state == S_DONE) && out_free;
    end

    // next state
    always_comb begin
        n_state   = r_state;
        n_ch      = r_ch;
        n_m_valid = r_m_valid;
        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_MUL_U;
                end
            end
            S_MUL_U: begin
                n_state = i_sts.sat ? S_SEG : S_DIVU_GO;
            end
            S_DIVU_GO: begin
                n_state = S_DIVU_WAIT;
            end
            S_DIVU_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_SEG;
                end
            end
            S_SEG: begin
                n_ch    = CH_RED;
                n_state = S_MUL_F;
            end
            S_MUL_F: begin
                n_state = S_DIVF_GO;
            end
            S_DIVF_GO: begin
                n_state = S_DIVF_WAIT;
            end
            S_DIVF_WAIT: begin
                if (i_sts.div_done) begin
                    case (r_ch)
                        CH_RED:   n_ch = CH_GREEN;
                        CH_GREEN: n_ch = CH_BLUE;
                        default:  n_ch = CH_RED;
                    endcase
                    n_state = (r_ch == CH_BLUE) ? S_DONE : S_MUL_F;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ch      <= CH_RED;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ch      <= n_ch;
            r_m_valid <= n_m_valid;
        end
    end

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> out_free)
        else $error("result register loaded while still full");

    // an accepted item starts the sequence
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_MUL_U))
        else $error("accepted item did not start");

    // divider finishes only while the controller waits for it
    a_div_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == S_DIVU_WAIT || r_state == S_DIVF_WAIT))
        else $error("unexpected divider completion");

    // the last filter leads to the result stage
    a_blue_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.wr_f && r_ch == CH_BLUE) |=> (r_state == S_DONE))
        else $error("filter sequence did not end on blue");

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

// testbench for the voltage heat colour led driver
// predicts duties and the flash flag per reading pair and checks every result item
// depends on vhcld_pkg and voltage_heat_color_led_driver
module testbench;
    import vhcld_pkg::*;

    localparam int SMOOTH_DIV   = 100;
    localparam int FLASH_CYCLE  = 2500;
    localparam int ADC_MAX      = (1 << ADC_W) - 1;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 100;
    localparam int RUN_LIMIT_NS = 40_000_000;

    typedef struct packed {
        logic [DUTY_W-1:0] red;
        logic [DUTY_W-1:0] green;
        logic [DUTY_W-1:0] blue;
        logic              flash;
    } t_led_result;

    // block ports, all inputs known from time zero
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    t_cfg_idx            i_cfg_addr  = CFG_FULL_SCALE;
    logic [DUTY_W-1:0]   i_cfg_wdata = '0;
    logic                i_s_tvalid  = 1'b0;
    logic                o_s_tready;
    logic [2*ADC_W-1:0]  i_s_tdata   = '0;   // supply_reading, level_reading
    logic                o_m_tvalid;
    logic                i_m_tready  = 1'b0;
    logic [3*DUTY_W-1:0] o_m_tdata;          // red_duty, green_duty, blue_duty
    logic                o_m_tuser;          // flash_active

    // predictor copy of the registers and the state
    logic [DUTY_W-1:0] period_reg     = RST_PERIOD;
    logic [ADC_W-1:0]  span_low_reg   = RST_SPAN_LOW;
    logic [ADC_W-1:0]  span_high_reg  = RST_SPAN_HIGH;
    logic [ADC_W-1:0]  low_supply_reg = RST_LOW_SUP;
    logic [SM_W-1:0]   smooth_red     = '0;
    logic [SM_W-1:0]   smooth_green   = '0;
    logic [SM_W-1:0]   smooth_blue    = '0;
    logic [CNT_W-1:0]  flash_ms       = '0;

    t_led_result      expected_leds[$];
    int               error_count  = 0;
    int               src_idle_pct = 0;
    int               snk_idle_pct = 0;
    logic             hold_req     = 1'b0;
    int               hold_count   = 0;
    logic [ADC_W-1:0] last_level   = '0;

    voltage_heat_color_led_driver #(
        .SMOOTH_DIVISOR(SMOOTH_DIV),
        .FLASH_CYCLE_MS(FLASH_CYCLE)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #10 i_clk = ~i_clk;

    // run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("== FAIL ==");
        $finish;
    end

    // first-order filter step in q.8, floor division
    function automatic logic [SM_W-1:0] smooth_step(logic [SM_W-1:0] old,
                                                    longint unsigned target);
        longint unsigned prev;
        longint unsigned sum;
        prev = old;
        sum  = (target << FRAC_W) + prev * (SMOOTH_DIV - 1);
        return SM_W'(sum / SMOOTH_DIV);
    endfunction

    function automatic logic [DUTY_W-1:0] clamp_duty(logic [SM_W-1:0] sm,
                                                     longint unsigned p);
        longint unsigned whole;
        whole = sm >> FRAC_W;
        return DUTY_W'((whole > p) ? p : whole);
    endfunction

    // expected result of one reading pair, advances the filters and the flash count
    function automatic t_led_result predict_leds(logic [ADC_W-1:0] supply,
                                                 logic [ADC_W-1:0] level);
        longint unsigned p, pos, lv, lo, hi, tr, tg, tb;
        t_led_result     res;
        p  = period_reg;
        lv = level;
        lo = span_low_reg;
        hi = span_high_reg;
        // position over the span, saturating, no division on an empty span
        if (lv <= lo)
            pos = 0;
        else if (lv >= hi)
            pos = 4 * p;
        else
            pos = (lv - lo) * 4 * p / (hi - lo);
        // four colour segments
        if (pos < p) begin
            tr = 0;            tg = pos;          tb = p;
        end else if (pos < 2 * p) begin
            tr = 0;            tg = p;            tb = 2 * p - pos;
        end else if (pos < 3 * p) begin
            tr = pos - 2 * p;  tg = p;            tb = 0;
        end else begin
            tr = p;            tg = 4 * p - pos;  tb = 0;
        end
        smooth_red   = smooth_step(smooth_red, tr);
        smooth_green = smooth_step(smooth_green, tg);
        smooth_blue  = smooth_step(smooth_blue, tb);
        res.red   = clamp_duty(smooth_red, p);
        res.green = clamp_duty(smooth_green, p);
        res.blue  = clamp_duty(smooth_blue, p);
        // low supply flash windows, on the count before it advances
        res.flash = (supply < low_supply_reg) &&
                    ((flash_ms > FL_W1_LO && flash_ms < FL_W1_HI) ||
                     (flash_ms > FL_W2_LO && flash_ms < FL_W2_HI) ||
                     (flash_ms > FL_W3_LO && flash_ms < FL_W3_HI));
        if (res.flash) begin
            res.red   = DUTY_W'(p);
            res.green = DUTY_W'(p);
            res.blue  = DUTY_W'(p);
        end
        flash_ms = (flash_ms + 1 >= FLASH_CYCLE) ? '0 : flash_ms + 1'b1;
        return res;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t ns: %s", $time, what);
        error_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin : check_results
        t_led_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_leds.size() == 0) begin
                report_mismatch("result item with no reading pending");
            end else begin
                want = expected_leds.pop_front();
                if (o_m_tdata[DUTY_W-1:0] !== want.red)
                    report_mismatch($sformatf("red_duty %0d, expected %0d",
                                              o_m_tdata[DUTY_W-1:0], want.red));
                if (o_m_tdata[2*DUTY_W-1:DUTY_W] !== want.green)
                    report_mismatch($sformatf("green_duty %0d, expected %0d",
                                              o_m_tdata[2*DUTY_W-1:DUTY_W], want.green));
                if (o_m_tdata[3*DUTY_W-1:2*DUTY_W] !== want.blue)
                    report_mismatch($sformatf("blue_duty %0d, expected %0d",
                                              o_m_tdata[3*DUTY_W-1:2*DUTY_W], want.blue));
                if (o_m_tuser !== want.flash)
                    report_mismatch($sformatf("flash_active %0b, expected %0b",
                                              o_m_tuser, want.flash));
            end
        end
    end

    // receiver: random stalls, or one long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_req && hold_count < HOLD_CYCLES) begin
            i_m_tready <= 1'b0;
            hold_count <= hold_count + 1;
        end else begin
            if (!hold_req)
                hold_count <= 0;
            i_m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // offer one reading pair and record its expectation once taken
    task automatic send_reading(logic [ADC_W-1:0] supply, logic [ADC_W-1:0] level);
        @(negedge i_clk);
        // sender idles cycle by cycle with the set probability
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {level, supply};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        expected_leds.push_back(predict_leds(supply, level));
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [DUTY_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_FULL_SCALE: period_reg     = value;
            CFG_SPAN_LOW:   span_low_reg   = value[ADC_W-1:0];
            CFG_SPAN_HIGH:  span_high_reg  = value[ADC_W-1:0];
            CFG_LOW_SUPPLY: low_supply_reg = value[ADC_W-1:0];
            default: ;
        endcase
    endtask

    // stop offering and wait for every pending result item
    task automatic wait_idle();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (expected_leds.size() != 0) @(negedge i_clk);
    endtask

    // level: held for runs so the filters settle, spread over and around the span
    function automatic logic [ADC_W-1:0] pick_level();
        int r;
        r = $urandom_range(0, 99);
        if (r >= 40) begin
            r = $urandom_range(0, 99);
            if (r < 15)
                last_level = ADC_W'($urandom_range(0, span_low_reg));
            else if (r < 30)
                last_level = ADC_W'($urandom_range(span_high_reg, ADC_MAX));
            else if (r < 85 && span_low_reg < span_high_reg)
                last_level = ADC_W'($urandom_range(span_low_reg, span_high_reg));
            else
                last_level = ADC_W'($urandom_range(0, ADC_MAX));
        end
        return last_level;
    endfunction

    // supply: anywhere, or right around the threshold
    function automatic logic [ADC_W-1:0] pick_supply();
        int v;
        if ($urandom_range(0, 1) == 0)
            return ADC_W'($urandom_range(0, ADC_MAX));
        v = int'(low_supply_reg) + int'($urandom_range(0, 2)) - 1;
        if (v < 0)
            v = 0;
        if (v > ADC_MAX)
            v = ADC_MAX;
        return ADC_W'(v);
    endfunction

    task automatic apply_random_setting();
        int                sel;
        int                lo, hi, thr;
        logic [DUTY_W-1:0] per;
        case ($urandom_range(0, 4))
            0:       per = DUTY_W'($urandom_range(1, 8));
            1:       per = RST_PERIOD;
            2:       per = '1;
            3:       per = DUTY_W'($urandom_range(100, 5000));
            default: per = DUTY_W'($urandom_range(1, 65535));
        endcase
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
            lo = 0;
            hi = ADC_MAX;
        end else if (sel < 3) begin
            // empty or single-point span
            hi = $urandom_range(0, ADC_MAX);
            lo = $urandom_range(hi, ADC_MAX);
        end else begin
            lo = $urandom_range(0, ADC_MAX - 1);
            hi = $urandom_range(lo + 1, ADC_MAX);
        end
        sel = $urandom_range(0, 4);
        if (sel < 2)
            thr = 0;
        else if (sel == 2)
            thr = ADC_MAX;
        else
            thr = $urandom_range(0, ADC_MAX);
        write_reg(CFG_FULL_SCALE, per);
        write_reg(CFG_SPAN_LOW, DUTY_W'(lo));
        write_reg(CFG_SPAN_HIGH, DUTY_W'(hi));
        write_reg(CFG_LOW_SUPPLY, DUTY_W'(thr));
    endtask

    // reset setting: span ends, segment boundaries and saturation
    task automatic test_colour_segments();
        logic [ADC_W-1:0] levels [10] = '{0, 819, 820, 1126, 1433, 1740, 1739,
                                          2046, 2047, 4095};
        foreach (levels[k])
            send_reading(k[0] ? ADC_MAX : 0, levels[k]);
        wait_idle();
    endtask

    // span with high at or below low
    task automatic test_empty_span();
        write_reg(CFG_SPAN_LOW, 3000);
        write_reg(CFG_SPAN_HIGH, 100);
        send_reading(0, 3000);
        send_reading(ADC_MAX, 3001);
        send_reading(0, 0);
        send_reading(ADC_MAX, ADC_MAX);
        wait_idle();
        write_reg(CFG_SPAN_LOW, 2000);
        write_reg(CFG_SPAN_HIGH, 2000);
        send_reading(0, 2000);
        send_reading(0, 2001);
        send_reading(0, 1999);
        wait_idle();
    endtask

    // full-scale period, then lowered so the duties clamp, then zero
    task automatic test_period_extremes();
        write_reg(CFG_SPAN_LOW, 0);
        write_reg(CFG_SPAN_HIGH, ADC_MAX);
        write_reg(CFG_FULL_SCALE, '1);
        send_reading(ADC_MAX, ADC_MAX);
        send_reading(0, 2048);
        send_reading(ADC_MAX, 1);
        wait_idle();
        write_reg(CFG_FULL_SCALE, 1);
        send_reading(0, ADC_MAX);
        wait_idle();
        write_reg(CFG_FULL_SCALE, 0);
        send_reading(0, 2048);
        send_reading(ADC_MAX, ADC_MAX);
        wait_idle();
    endtask

    task automatic test_random_readings(int src_pct, int snk_pct, int chunks,
                                       int chunk_items);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        repeat (chunks) begin
            apply_random_setting();
            repeat (chunk_items)
                send_reading(pick_supply(), pick_level());
            wait_idle();
        end
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_output_backpressure();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_req <= 1'b1;
        repeat (6)
            send_reading(pick_supply(), pick_level());
        wait_idle();
        hold_req <= 1'b0;
    endtask

    // flash enabled through the three windows of the cycle and their edges
    task automatic test_flash_windows();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_reg(CFG_FULL_SCALE, RST_PERIOD);
        write_reg(CFG_SPAN_LOW, RST_SPAN_LOW);
        write_reg(CFG_SPAN_HIGH, RST_SPAN_HIGH);
        write_reg(CFG_LOW_SUPPLY, ADC_MAX);
        while (flash_ms <= FL_W3_HI + 10) begin
            send_reading(ADC_W'(($urandom_range(0, 9) == 0) ?
                                ADC_MAX : $urandom_range(0, ADC_MAX - 1)),
                         pick_level());
        end
        wait_idle();
    endtask

    // test sequence
    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_colour_segments();
        test_empty_span();
        test_period_extremes();
        test_flash_windows();
        test_random_readings(19, 64, 4, 48);
        test_random_readings(64, 19, 4, 48);
        test_random_readings(0, 0, 4, 48);
        test_output_backpressure();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_leds.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
sv/vhcld_pkg.sv
sv/vhcld_div.sv
sv/vhcld_dp.sv
sv/vhcld_ctrl.sv
sv/voltage_heat_color_led_driver.sv
tb/testbench.sv
